[rtl/core/hvps_pkg.sv]
// shared types, codes and reset constants of the hv power-up sequencer
package hvps_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STAMP_W    = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HANDOVER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_OPEN = 2'd2;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] PRECHARGE_RST   = 16'd5000;
	localparam logic [CFG_DATA_W-1:0] HANDOVER_RST    = 16'd200;
	localparam logic [CFG_DATA_W-1:0] CHARGE_OPEN_RST = 16'd500;

	// external state codes
	localparam logic [2:0] CODE_OFF    = 3'd0;
	localparam logic [2:0] CODE_ACC    = 3'd1;
	localparam logic [2:0] CODE_IGN    = 3'd2;
	localparam logic [2:0] CODE_DCDC   = 3'd3;
	localparam logic [2:0] CODE_ON     = 3'd4;
	localparam logic [2:0] CODE_CHARGE = 3'd5;
	localparam logic [2:0] CODE_FAULT  = 3'd6;

	// one-hot sequencer state
	typedef enum logic [6:0] {
		ST_OFF    = 7'b0000001,
		ST_ACC    = 7'b0000010,
		ST_IGN    = 7'b0000100,
		ST_DCDC   = 7'b0001000,
		ST_ON     = 7'b0010000,
		ST_CHARGE = 7'b0100000,
		ST_FAULT  = 7'b1000000
	} seq_st_t;

	typedef struct packed {
		logic key_acc;
		logic key_ign;
		logic charge_enable;
		logic discharge_enable;
		logic charge_contactor;
		logic kill_event;
		logic [STAMP_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [2:0] seq_state;
		logic       precharge_relay;
		logic       hv_contactor;
		logic       hv_dcdc_enable;
		logic       aux_dcdc_disable;
	} result_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] precharge_ms;
		logic [CFG_DATA_W-1:0] handover_ms;
		logic [CFG_DATA_W-1:0] charge_open_ms;
	} cfg_t;

	typedef struct packed {
		logic pre;
		logic hvc;
		logic hvdcdc;
		logic aux;
	} drive_t;

	typedef struct packed {
		seq_st_t            cur;
		seq_st_t            prev;
		logic [STAMP_W-1:0] entry;
		drive_t             drv;
	} core_t;

	// one-hot state to external code
	function automatic logic [2:0] st_code(input seq_st_t st);
		logic [2:0] code;
		unique case (st)
			ST_OFF:    code = CODE_OFF;
			ST_ACC:    code = CODE_ACC;
			ST_IGN:    code = CODE_IGN;
			ST_DCDC:   code = CODE_DCDC;
			ST_ON:     code = CODE_ON;
			ST_CHARGE: code = CODE_CHARGE;
			default:   code = CODE_FAULT;
		endcase
		return code;
	endfunction

endpackage

[rtl/core/hvps_if.sv]
// valid/ready channels for sample words and result words
interface hvps_in_if;
	logic              valid;
	logic              ready;
	hvps_pkg::sample_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hvps_out_if;
	logic              valid;
	logic              ready;
	hvps_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/hv_power_up_sequencer_unit.sv]
// top level of the hv power-up sequencer
//
//  channel     dir  handshake      word
//  sample_ch   in   valid/ready    key, enable, contactor levels, kill, now_ms
//  result_ch   out  valid/ready    seq_state and four drive levels
//  cfg_*       in   write enable   three 16-bit delay registers
//
// one word per cycle sustained while result_ch is ready; a sample is
// registered in the input register, then the step logic (one 32-bit
// subtract and compare) loads the result register, from which the
// result word leaves on result_ch.
// arst_n resets state to off, drives low and delays to their defaults.
// a stalled result holds the pipe; sample_ch stays ready while the input
// register is empty or can move into a free or draining result register.
module hv_power_up_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hvps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hvps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	hvps_in_if.sink                         sample_ch,
	hvps_out_if.source                      result_ch
);
	import hvps_pkg::*;

	cfg_t    cfg;
	core_t   core_q, core_d;
	result_t res_d;
	result_t res_s2;
	sample_t sample_s1;
	logic    valid_s1, valid_s2;
	logic    adv_s1;

	hvps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hvps_step u_step (
		.core_q (core_q),
		.smp    (sample_s1),
		.cfg    (cfg),
		.core_d (core_d),
		.res    (res_d)
	);

	// stage 1 moves on when the result register is free or draining
	assign adv_s1          = !valid_s2 || result_ch.ready;
	assign sample_ch.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.ready && sample_ch.valid) sample_s1 <= sample_ch.payload;
	end

	// sequencer state, updated once per stepped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q.cur   <= ST_OFF;
			core_q.prev  <= ST_OFF;
			core_q.entry <= '0;
			core_q.drv   <= '0;
		end else if (valid_s1 && adv_s1) begin
			core_q <= core_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) res_s2 <= res_d;
	end

	assign result_ch.valid   = valid_s2;
	assign result_ch.payload = res_s2;

endmodule

[rtl/core/hvps_cfg.sv]
// delay configuration registers
module hvps_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hvps_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hvps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output hvps_pkg::cfg_t                    cfg
);
	import hvps_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.precharge_ms   <= PRECHARGE_RST;
			cfg_q.handover_ms    <= HANDOVER_RST;
			cfg_q.charge_open_ms <= CHARGE_OPEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PRECHARGE:   cfg_q.precharge_ms   <= cfg_wdata;
				REG_HANDOVER:    cfg_q.handover_ms    <= cfg_wdata;
				REG_CHARGE_OPEN: cfg_q.charge_open_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/hvps_step.sv]
// next-state and drive logic for one sample word
module hvps_step (
	input  hvps_pkg::core_t   core_q,
	input  hvps_pkg::sample_t smp,
	input  hvps_pkg::cfg_t    cfg,
	output hvps_pkg::core_t   core_d,
	output hvps_pkg::result_t res
);
	import hvps_pkg::*;

	logic                  acc, ign, ce, de, cc, all_ok;
	seq_st_t               st;
	logic                  restamp;
	logic [STAMP_W-1:0]    entry_n;
	logic [STAMP_W-1:0]    elapsed;
	logic [CFG_DATA_W-1:0] delay;
	logic                  expired;

	assign acc    = smp.key_acc;
	assign ign    = smp.key_ign;
	assign ce     = smp.charge_enable;
	assign de     = smp.discharge_enable;
	assign cc     = smp.charge_contactor;
	assign all_ok = ign && de && acc && ce;

	// kill forces fault ahead of the step
	assign st = smp.kill_event ? ST_FAULT : core_q.cur;

	// entry stamp refresh on the first step in each state but off and fault
	always_comb begin
		unique case (st)
			ST_ACC:    restamp = (core_q.prev == ST_ON);
			ST_IGN:    restamp = (core_q.prev == ST_ACC);
			ST_DCDC:   restamp = (core_q.prev == ST_IGN);
			ST_ON:     restamp = (core_q.prev == ST_DCDC);
			ST_CHARGE: restamp = (core_q.prev == ST_ON);
			default:   restamp = 1'b0;
		endcase
	end

	assign entry_n = restamp ? smp.now_ms : core_q.entry;

	// one wrap-around subtract and compare against the state's delay
	always_comb begin
		unique case (st)
			ST_IGN:    delay = cfg.precharge_ms;
			ST_DCDC:   delay = cfg.handover_ms;
			default:   delay = cfg.charge_open_ms;
		endcase
	end

	assign elapsed = smp.now_ms - entry_n;
	assign expired = (elapsed >= {{(STAMP_W-CFG_DATA_W){1'b0}}, delay});

	// state transitions and drive updates
	always_comb begin
		core_d       = core_q;
		core_d.entry = entry_n;
		core_d.cur   = st;
		unique case (st)
			ST_OFF: begin
				core_d.prev = ST_ON;
				core_d.drv  = '0;
				if (acc && ce && de) core_d.cur = ST_ACC;
			end
			ST_ACC: begin
				core_d.prev = ST_ACC;
				if (all_ok) core_d.cur = ST_IGN;
				else if (!acc || !ce || !de) core_d.cur = ST_OFF;
			end
			ST_IGN: begin
				if (restamp) core_d.drv.pre = 1'b1;
				core_d.prev = ST_IGN;
				if (!all_ok) begin
					core_d.cur = ST_FAULT;
				end else if (expired) begin
					core_d.drv.hvc = 1'b1;
					core_d.cur     = ST_DCDC;
				end
			end
			ST_DCDC: begin
				if (restamp) begin
					core_d.drv.hvdcdc = 1'b1;
					core_d.drv.pre    = 1'b0;
				end
				core_d.prev = ST_DCDC;
				if (!all_ok) begin
					core_d.cur = ST_FAULT;
				end else if (expired) begin
					core_d.drv.aux = 1'b1;
					core_d.cur     = ST_ON;
				end
			end
			ST_ON: begin
				core_d.prev = ST_ON;
				if (!acc || !ce || (!de && !cc)) core_d.cur = ST_FAULT;
				else if (!de && cc) core_d.cur = ST_CHARGE;
			end
			ST_CHARGE: begin
				if (restamp) core_d.prev = ST_CHARGE;
				if (expired) begin
					core_d.drv.hvc    = 1'b0;
					core_d.drv.hvdcdc = 1'b0;
				end
				if (!acc || !ce || de || !cc) core_d.cur = ST_FAULT;
			end
			default: begin
				core_d.cur        = ST_FAULT;
				core_d.drv.aux    = 1'b0;
				core_d.drv.hvdcdc = 1'b0;
			end
		endcase
	end

	// result word taken after the step
	always_comb begin
		res.seq_state        = st_code(core_d.cur);
		res.precharge_relay  = core_d.drv.pre;
		res.hv_contactor     = core_d.drv.hvc;
		res.hv_dcdc_enable   = core_d.drv.hvdcdc;
		res.aux_dcdc_disable = core_d.drv.aux;
	end

endmodule

[rtl/core/hvps_checker.sv]
// port-level checks of the hv power-up sequencer, bound to the top level
module hvps_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input hvps_pkg::result_t res
);
	import hvps_pkg::*;

	logic res_acc;
	logic fault_seen_q;

	assign res_acc = res_valid && res_ready;

	// remembers a delivered fault word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_seen_q <= 1'b0;
		end else if (res_acc && res.seq_state == CODE_FAULT) begin
			fault_seen_q <= 1'b1;
		end
	end

	// fault is left only by reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fault_seen_q |-> res.seq_state == CODE_FAULT)
		else $error("sequencer left fault without reset");

	// after a fault word is delivered, the hv dc-dc and the aux disable stay dropped
	a_fault_drives: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fault_seen_q |->
		!res.hv_dcdc_enable && !res.aux_dcdc_disable)
		else $error("fault word with converter drives active");

	// off means every drive low
	a_off_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.seq_state == CODE_OFF |->
		!res.precharge_relay && !res.hv_contactor &&
		!res.hv_dcdc_enable && !res.aux_dcdc_disable)
		else $error("off word with a drive active");

	// stalled result word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed under stall");

endmodule

bind hv_power_up_sequencer_unit hvps_checker u_hvps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.res       (result_ch.payload)
);
